/* hw/rtl/rgbc_pkg.sv */
// rgbc_pkg: shared types and constants of the rgbc color classifier
`default_nettype none

package rgbc_pkg;

  // register file layout
  localparam int CfgBits  = 16;
  localparam int AddrBits = 5;
  localparam int DataBits = 32;

  // register indexes, taken from paddr word offset
  typedef enum logic [2:0] {
    IdxBlack = 3'd0,
    IdxClear = 3'd1,
    IdxRed   = 3'd2,
    IdxGreen = 3'd3,
    IdxBlue  = 3'd4
  } reg_idx_e;

  // register reset values
  localparam logic [CfgBits-1:0] BlackRst = 16'd0;
  localparam logic [CfgBits-1:0] ClearRst = 16'd993;
  localparam logic [CfgBits-1:0] RedRst   = 16'd484;
  localparam logic [CfgBits-1:0] GreenRst = 16'd268;
  localparam logic [CfgBits-1:0] BlueRst  = 16'd183;

  // lane pipeline depth: numerator stage plus one stage per quotient bit
  localparam int PctBits = 8;
  localparam int LaneLat = PctBits + 1;
  localparam logic [6:0] PctScale = 7'd100;

  // threshold tree constants, in percent
  localparam logic [PctBits-1:0] RedTop    = 8'd65;
  localparam logic [PctBits-1:0] GreenLow  = 8'd11;
  localparam logic [PctBits-1:0] RedWarm   = 8'd52;
  localparam logic [PctBits-1:0] GreenYel  = 8'd29;
  localparam logic [PctBits-1:0] BlueYel   = 8'd21;
  localparam logic [PctBits-1:0] RedMid    = 8'd35;
  localparam logic [PctBits-1:0] RedWhite  = 8'd45;
  localparam logic [PctBits-1:0] RedLow    = 8'd15;
  localparam logic [PctBits-1:0] BlueCool  = 8'd30;

  // color codes
  typedef enum logic [3:0] {
    ColNone      = 4'd0,
    ColRed       = 4'd1,
    ColGreen     = 4'd2,
    ColBlue      = 4'd3,
    ColYellow    = 4'd4,
    ColPink      = 4'd5,
    ColOrange    = 4'd6,
    ColLightBlue = 4'd7,
    ColWhite     = 4'd8,
    ColBlack     = 4'd9
  } color_e;

  // what the lanes hand to the merge stage
  typedef struct packed {
    logic               vld;
    logic               blk;
    logic [PctBits-1:0] pct_r;
    logic [PctBits-1:0] pct_g;
    logic [PctBits-1:0] pct_b;
  } merge_in_t;

endpackage

`default_nettype wire

/* hw/rtl/rgbc_lane.sv */
// rgbc_lane: pipelined percentage of one channel against clear, clamped to 0..255
`default_nettype none

module rgbc_lane #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic signed [SAMPLE_BITS+1:0] chan_i,
  input  wire logic signed [SAMPLE_BITS+1:0] clear_i,
  output logic [rgbc_pkg::PctBits-1:0]       pct_o
);
  import rgbc_pkg::*;

  localparam int CW = SAMPLE_BITS + 2;
  localparam int RW = SAMPLE_BITS + PctBits;

  logic [RW-1:0]          rem_q [0:PctBits-1];
  logic [SAMPLE_BITS-1:0] den_q [0:PctBits-1];
  logic [PctBits-1:0]     quo_q [0:PctBits];
  logic                   zr_q  [0:PctBits];
  logic                   sat_q [0:PctBits];

  logic          zr_d;
  logic [RW-1:0] num_d;

  // numerator stage: 100 * channel, zero when clear or channel is not usable
  assign zr_d  = clear_i[CW-1] || (clear_i == '0) || chan_i[CW-1];
  assign num_d = RW'(chan_i[SAMPLE_BITS-1:0]) * RW'(PctScale);

  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_d;
    den_q[0] <= clear_i[SAMPLE_BITS-1:0];
    quo_q[0] <= '0;
    zr_q[0]  <= zr_d;
    sat_q[0] <= 1'b0;
  end

  // restoring divider, one quotient bit per stage, msb first
  for (genvar k = 0; k < PctBits; k++) begin : g_div
    logic [RW-1:0] shf;
    logic [RW-1:0] dif;
    logic          take;
    logic          sat_d;

    assign shf  = RW'(den_q[k]) << (PctBits - 1 - k);
    assign take = rem_q[k] >= shf;
    assign dif  = rem_q[k] - shf;

    // quotient of 256 or more saturates, decided on the first bit
    if (k == 0) begin : g_sat
      assign sat_d = rem_q[k] >= (RW'(den_q[k]) << PctBits);
    end else begin : g_pass
      assign sat_d = sat_q[k];
    end

    always_ff @(posedge clk_i) begin
      quo_q[k+1] <= {quo_q[k][PctBits-2:0], take};
      zr_q[k+1]  <= zr_q[k];
      sat_q[k+1] <= sat_d;
    end

    if (k < PctBits - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_q[k+1] <= take ? dif : rem_q[k];
        den_q[k+1] <= den_q[k];
      end
    end
  end

  // clamp to the percentage range
  always_comb begin
    if (zr_q[PctBits]) begin
      pct_o = '0;
    end else if (sat_q[PctBits]) begin
      pct_o = '1;
    end else begin
      pct_o = quo_q[PctBits];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rgbc_merge.sv */
// rgbc_merge: threshold tree over the lane percentages, registered result word
`default_nettype none

module rgbc_merge (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire rgbc_pkg::merge_in_t  lanes_i,
  output logic                      done_o,
  output rgbc_pkg::color_e          code_o
);
  import rgbc_pkg::*;

  color_e code_d;
  color_e code_q;
  logic   done_q;

  // decision tree, black card first
  always_comb begin
    if (lanes_i.blk) begin
      code_d = ColBlack;
    end else if (lanes_i.pct_r >= RedTop) begin
      code_d = (lanes_i.pct_g < GreenLow) ? ColRed : ColOrange;
    end else if (lanes_i.pct_r >= RedWarm) begin
      code_d = (lanes_i.pct_g >= GreenYel && lanes_i.pct_b < BlueYel) ? ColYellow : ColPink;
    end else if (lanes_i.pct_r >= RedMid) begin
      code_d = (lanes_i.pct_r >= RedWhite) ? ColWhite : ColLightBlue;
    end else if (lanes_i.pct_r >= RedLow) begin
      code_d = (lanes_i.pct_b >= BlueCool) ? ColBlue : ColGreen;
    end else begin
      code_d = ColNone;
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= lanes_i.vld;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (lanes_i.vld) begin
      code_q <= code_d;
    end
  end

  assign done_o = done_q;
  assign code_o = code_q;

endmodule

`default_nettype wire

/* hw/rtl/rgbc_color_classifier.sv */
// rgbc_color_classifier: top level with register file, correction stage, lanes and merge
// a result strobes on done_o once the word has passed the correction register, the lane stages and the merge register
// throughput: one word per cycle, the three divider lanes are fully pipelined
// busy_o stays low; the receiver takes every result in its strobe cycle
// rst_ni (async, active low) clears the pipeline valids and loads register defaults
`default_nettype none

module rgbc_color_classifier #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // command channel
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic [SAMPLE_BITS-1:0]          lit_clear_i,
  input  wire logic [SAMPLE_BITS-1:0]          lit_red_i,
  input  wire logic [SAMPLE_BITS-1:0]          lit_green_i,
  input  wire logic [SAMPLE_BITS-1:0]          lit_blue_i,
  input  wire logic [SAMPLE_BITS-1:0]          dark_clear_i,
  input  wire logic [SAMPLE_BITS-1:0]          dark_red_i,
  input  wire logic [SAMPLE_BITS-1:0]          dark_green_i,
  input  wire logic [SAMPLE_BITS-1:0]          dark_blue_i,
  // result channel
  output logic                                 done_o,
  output logic [3:0]                           color_code_o,
  // register port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rgbc_pkg::AddrBits-1:0]   paddr,
  input  wire logic [rgbc_pkg::DataBits-1:0]   pwdata,
  output logic [rgbc_pkg::DataBits-1:0]        prdata,
  output logic                                 pready
);
  import rgbc_pkg::*;

  localparam int CW = SAMPLE_BITS + 2;
  localparam logic [SAMPLE_BITS-1:0] CfgMask =
    SAMPLE_BITS'((64'd1 << CfgBits) - 64'd1);

  logic [SAMPLE_BITS-1:0] black_q, clear_off_q, red_off_q, green_off_q, blue_off_q;
  logic [SAMPLE_BITS-1:0] wdata;
  logic                   wr_en;
  reg_idx_e               idx;

  logic                   accept;
  logic signed [CW-1:0]   clr_d, clr_q;
  logic signed [CW-1:0]   chan_d [0:2];
  logic signed [CW-1:0]   chan_q [0:2];
  logic [PctBits-1:0]     pct [0:2];
  logic                   vld_q [0:LaneLat];
  logic                   blk_q [0:LaneLat];
  merge_in_t              merge_in;
  color_e                 code;

  // register port decode
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[AddrBits-1:2]);
  assign wdata  = pwdata[SAMPLE_BITS-1:0] & CfgMask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      black_q     <= SAMPLE_BITS'(BlackRst);
      clear_off_q <= SAMPLE_BITS'(ClearRst);
      red_off_q   <= SAMPLE_BITS'(RedRst);
      green_off_q <= SAMPLE_BITS'(GreenRst);
      blue_off_q  <= SAMPLE_BITS'(BlueRst);
    end else if (wr_en) begin
      case (idx)
        IdxBlack: black_q     <= wdata;
        IdxClear: clear_off_q <= wdata;
        IdxRed:   red_off_q   <= wdata;
        IdxGreen: green_off_q <= wdata;
        IdxBlue:  blue_off_q  <= wdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (idx)
      IdxBlack: prdata = DataBits'(black_q);
      IdxClear: prdata = DataBits'(clear_off_q);
      IdxRed:   prdata = DataBits'(red_off_q);
      IdxGreen: prdata = DataBits'(green_off_q);
      IdxBlue:  prdata = DataBits'(blue_off_q);
      default:  prdata = '0;
    endcase
  end

  // command handshake, the pipeline takes a word every cycle
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // dark and crosstalk correction, signed
  assign clr_d = $signed({2'b00, lit_clear_i}) - $signed({2'b00, dark_clear_i})
               - $signed({2'b00, clear_off_q});
  assign chan_d[0] = $signed({2'b00, lit_red_i}) - $signed({2'b00, dark_red_i})
                   - $signed({2'b00, red_off_q});
  assign chan_d[1] = $signed({2'b00, lit_green_i}) - $signed({2'b00, dark_green_i})
                   - $signed({2'b00, green_off_q});
  assign chan_d[2] = $signed({2'b00, lit_blue_i}) - $signed({2'b00, dark_blue_i})
                   - $signed({2'b00, blue_off_q});

  always_ff @(posedge clk_i) begin
    if (accept) begin
      clr_q     <= clr_d;
      chan_q[0] <= chan_d[0];
      chan_q[1] <= chan_d[1];
      chan_q[2] <= chan_d[2];
    end
  end

  // valid chain alongside the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= LaneLat; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      vld_q[0] <= accept;
      for (int i = 1; i <= LaneLat; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // black flag travels with the word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      blk_q[0] <= (lit_clear_i <= black_q);
    end
    for (int i = 1; i <= LaneLat; i++) begin
      blk_q[i] <= blk_q[i-1];
    end
  end

  // red, green and blue lanes
  for (genvar l = 0; l < 3; l++) begin : g_lane
    rgbc_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .chan_i (chan_q[l]),
      .clear_i(clr_q),
      .pct_o  (pct[l])
    );
  end

  // merge stage
  assign merge_in.vld   = vld_q[LaneLat];
  assign merge_in.blk   = blk_q[LaneLat];
  assign merge_in.pct_r = pct[0];
  assign merge_in.pct_g = pct[1];
  assign merge_in.pct_b = pct[2];

  rgbc_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .lanes_i(merge_in),
    .done_o (done_o),
    .code_o (code)
  );

  assign color_code_o = code;

`ifndef SYNTHESIS
  // every accepted word strobes a result after the full pipeline depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(LaneLat + 2) done_o)
    else $error("accepted word gave no result strobe");

  // no strobe without a word leaving the lanes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(vld_q[LaneLat]))
    else $error("result strobe without a word");

  // a black card always classifies as black
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[LaneLat] && blk_q[LaneLat] |=> color_code_o == ColBlack)
    else $error("black card not reported as black");
`endif

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking testbench of the rgbc color classifier, with directed and random words
module tb_top;
  import rgbc_pkg::*;

  localparam int SampleBits = 16;
  localparam int NumRegs    = 5;
  localparam int NumSlots   = 8;
  localparam int CycleLimit = 100000;

  // one set of sensor readings
  typedef struct packed {
    bit [SampleBits-1:0] lit_clear;
    bit [SampleBits-1:0] lit_red;
    bit [SampleBits-1:0] lit_green;
    bit [SampleBits-1:0] lit_blue;
    bit [SampleBits-1:0] dark_clear;
    bit [SampleBits-1:0] dark_red;
    bit [SampleBits-1:0] dark_green;
    bit [SampleBits-1:0] dark_blue;
  } reading_t;

  // shadow registers, color prediction and the queue of colors still owed
  class color_tracker;
    bit [CfgBits-1:0] regs [NumRegs];
    color_e           expected_colors [$];
    int               errors;

    function new();
      regs[IdxBlack] = BlackRst;
      regs[IdxClear] = ClearRst;
      regs[IdxRed]   = RedRst;
      regs[IdxGreen] = GreenRst;
      regs[IdxBlue]  = BlueRst;
      errors = 0;
    endfunction

    function void set_reg(int idx, bit [DataBits-1:0] data);
      if (idx < NumRegs) begin
        regs[idx] = data[CfgBits-1:0];
      end
    endfunction

    // channel share of clear in whole percent, clamped to 0..255
    function int unsigned share(longint chan, longint clr);
      longint p;
      if (clr <= 0) return 0;
      p = (100 * chan) / clr;
      if (p < 0) return 0;
      if (p > 255) return 255;
      return int'(p);
    endfunction

    function color_e classify_reading(reading_t rd);
      longint      cc, cr, cg, cb;
      int unsigned pr, pg, pb;
      cc = longint'(rd.lit_clear) - longint'(rd.dark_clear) - longint'(regs[IdxClear]);
      cr = longint'(rd.lit_red) - longint'(rd.dark_red) - longint'(regs[IdxRed]);
      cg = longint'(rd.lit_green) - longint'(rd.dark_green) - longint'(regs[IdxGreen]);
      cb = longint'(rd.lit_blue) - longint'(rd.dark_blue) - longint'(regs[IdxBlue]);
      pr = share(cr, cc);
      pg = share(cg, cc);
      pb = share(cb, cc);
      // black card wins over everything
      if (rd.lit_clear <= regs[IdxBlack]) return ColBlack;
      if (pr >= RedTop) return (pg < GreenLow) ? ColRed : ColOrange;
      if (pr >= RedWarm) return (pg >= GreenYel && pb < BlueYel) ? ColYellow : ColPink;
      if (pr >= RedMid) return (pr >= RedWhite) ? ColWhite : ColLightBlue;
      if (pr >= RedLow) return (pb >= BlueCool) ? ColBlue : ColGreen;
      return ColNone;
    endfunction

    function void note_reading(reading_t rd);
      expected_colors.push_back(classify_reading(rd));
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 100) $display("tb: mismatch: %s", msg);
    endtask

    task check_color(logic [3:0] code);
      color_e want;
      if (expected_colors.size() == 0) begin
        report_mismatch($sformatf("unexpected color word %0d", code));
      end else begin
        want = expected_colors.pop_front();
        if (code !== want) begin
          report_mismatch($sformatf("color_code got %0d want %0d (%s)", code, want, want.name()));
        end
      end
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [SampleBits-1:0] lit_clear_i, lit_red_i, lit_green_i, lit_blue_i;
  logic [SampleBits-1:0] dark_clear_i, dark_red_i, dark_green_i, dark_blue_i;
  logic                  done_o;
  logic [3:0]            color_code_o;
  logic                  psel, penable, pwrite, pready;
  logic [AddrBits-1:0]   paddr;
  logic [DataBits-1:0]   pwdata, prdata;

  color_tracker tracker;
  int           cycles = 0;

  rgbc_color_classifier #(.SAMPLE_BITS(SampleBits)) u_top (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result monitor, every strobe is taken
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) tracker.check_color(color_code_o);
  end

  function automatic bit [SampleBits-1:0] clip_sample(longint v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return v[SampleBits-1:0];
  endfunction

  // build a reading whose corrected channels come out as given under the current offsets
  function automatic reading_t shape_reading(longint cc, longint cr, longint cg, longint cb,
                                             longint dk);
    reading_t rd;
    rd.dark_clear = clip_sample(dk);
    rd.dark_red   = clip_sample(dk);
    rd.dark_green = clip_sample(dk);
    rd.dark_blue  = clip_sample(dk);
    rd.lit_clear  = clip_sample(cc + dk + tracker.regs[IdxClear]);
    rd.lit_red    = clip_sample(cr + dk + tracker.regs[IdxRed]);
    rd.lit_green  = clip_sample(cg + dk + tracker.regs[IdxGreen]);
    rd.lit_blue   = clip_sample(cb + dk + tracker.regs[IdxBlue]);
    return rd;
  endfunction

  // corrected channel as a random share of clear, sometimes negative
  function automatic longint random_channel(longint cc);
    if ($urandom_range(0, 7) == 0) return -longint'($urandom_range(1, 2000));
    return cc * longint'($urandom_range(0, 110)) / 100 + longint'($urandom_range(0, 8)) - 4;
  endfunction

  // mostly shaped readings that spread over the tree, the rest raw noise
  function automatic reading_t random_reading();
    reading_t rd;
    longint   cc;
    if ($urandom_range(0, 9) < 2) begin
      rd = {$urandom, $urandom, $urandom, $urandom};
      return rd;
    end
    if ($urandom_range(0, 15) == 0) cc = -longint'($urandom_range(0, 2000));
    else cc = longint'($urandom_range(1, 20000));
    return shape_reading(cc, random_channel(cc), random_channel(cc), random_channel(cc),
                         longint'($urandom_range(0, 4095)));
  endfunction

  // one word on the command channel, with an optional random gap first
  task send_reading(reading_t rd, bit quiet);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 8) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    lit_clear_i  <= rd.lit_clear;
    lit_red_i    <= rd.lit_red;
    lit_green_i  <= rd.lit_green;
    lit_blue_i   <= rd.lit_blue;
    dark_clear_i <= rd.dark_clear;
    dark_red_i   <= rd.dark_red;
    dark_green_i <= rd.dark_green;
    dark_blue_i  <= rd.dark_blue;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    tracker.note_reading(rd);
  endtask

  task random_burst(int count, int quiet_count);
    for (int i = 0; i < count; i++) send_reading(random_reading(), i < quiet_count);
  endtask

  // wait until every owed color has come back
  task drain();
    start_i <= 1'b0;
    while (tracker.expected_colors.size() != 0) @(posedge clk_i);
  endtask

  // one register port transfer: setup, access, then idle with psel low
  task reg_access(bit wr, int idx, logic [DataBits-1:0] data, output logic [DataBits-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= AddrBits'(idx * 4);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (wr) tracker.set_reg(idx, data);
  endtask

  task check_regs();
    logic [DataBits-1:0] rdata;
    for (int idx = 0; idx < NumRegs; idx++) begin
      reg_access(1'b0, idx, '0, rdata);
      if (rdata[CfgBits-1:0] !== tracker.regs[idx]) begin
        tracker.report_mismatch($sformatf("reg %0d read %0h want %0h", idx,
                                          rdata[CfgBits-1:0], tracker.regs[idx]));
      end
    end
  endtask

  // new register setting per phase; junk goes to the unused slots
  task configure(int phase);
    bit [CfgBits-1:0]    vals [NumRegs];
    logic [DataBits-1:0] rdata;
    for (int idx = 0; idx < NumRegs; idx++) begin
      case (phase)
        1: vals[idx] = '0;
        2: vals[idx] = '1;
        3: vals[idx] = CfgBits'($urandom);
        default: vals[idx] = CfgBits'((idx == IdxBlack) ? $urandom_range(0, 3000)
                                                        : $urandom_range(0, 1500));
      endcase
    end
    for (int idx = 0; idx < NumRegs; idx++) begin
      reg_access(1'b1, idx, {16'($urandom), vals[idx]}, rdata);
    end
    for (int idx = NumRegs; idx < NumSlots; idx++) reg_access(1'b1, idx, $urandom, rdata);
  endtask

  initial begin
    tracker = new();
    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    lit_clear_i  <= '0;
    lit_red_i    <= '0;
    lit_green_i  <= '0;
    lit_blue_i   <= '0;
    dark_clear_i <= '0;
    dark_red_i   <= '0;
    dark_green_i <= '0;
    dark_blue_i  <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_regs();

    // directed words at reset settings
    send_reading('0, 1'b0);                                       // black at zero threshold
    send_reading('1, 1'b0);                                       // clear negative, none
    send_reading(shape_reading(1000, 700, 50, 50, 0), 1'b0);      // red
    send_reading(shape_reading(1000, 700, 200, 50, 12), 1'b0);    // orange
    send_reading(shape_reading(1000, 550, 300, 100, 0), 1'b0);    // yellow
    send_reading(shape_reading(1000, 550, 300, 250, 0), 1'b0);    // pink, too much blue
    send_reading(shape_reading(1000, 550, 280, 100, 0), 1'b0);    // pink, too little green
    send_reading(shape_reading(1000, 500, 200, 200, 40), 1'b0);   // white
    send_reading(shape_reading(1000, 400, 300, 300, 0), 1'b0);    // light blue
    send_reading(shape_reading(1000, 200, 100, 350, 0), 1'b0);    // blue
    send_reading(shape_reading(1000, 200, 100, 100, 0), 1'b0);    // green
    send_reading(shape_reading(1000, 100, 400, 400, 0), 1'b0);    // none
    // thresholds exactly and one below
    send_reading(shape_reading(1000, 650, 110, 0, 0), 1'b0);
    send_reading(shape_reading(1000, 649, 109, 0, 0), 1'b0);
    send_reading(shape_reading(1000, 520, 290, 209, 0), 1'b0);
    send_reading(shape_reading(1000, 450, 0, 0, 0), 1'b0);
    send_reading(shape_reading(1000, 449, 0, 0, 0), 1'b0);
    send_reading(shape_reading(1000, 349, 0, 300, 0), 1'b0);
    send_reading(shape_reading(1000, 150, 0, 299, 0), 1'b0);
    send_reading(shape_reading(1000, 149, 0, 0, 0), 1'b0);
    // clear zero and below, negative channel, clamp, large products
    send_reading(shape_reading(0, 500, 500, 500, 0), 1'b0);
    send_reading(shape_reading(-500, 500, 500, 500, 0), 1'b0);
    send_reading(shape_reading(1000, -300, 0, 0, 0), 1'b0);
    send_reading(shape_reading(10, 30000, 0, 0, 0), 1'b0);
    send_reading(shape_reading(1, 60000, 60000, 60000, 0), 1'b0);

    // random words, the first stretch with no gaps
    random_burst(130, 100);
    for (int phase = 1; phase < 5; phase++) begin
      drain();
      configure(phase);
      check_regs();
      random_burst(130, 0);
    end
    drain();
    repeat (LaneLat + 12) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/rgbc_pkg.sv
hw/rtl/rgbc_lane.sv
hw/rtl/rgbc_merge.sv
hw/rtl/rgbc_color_classifier.sv
tb/tb_top.sv
